// ===== hw/rtl/pva_pkg.sv =====
// Shared types, constants and codes of the polyphonic voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int NOTE_W     = 7;
    localparam int LEVEL_W    = 16;
    localparam int SLOT_W     = 3;
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE     = 16'd32768;
    localparam logic [LEVEL_W-1:0] ATTACK_RESET  = 16'd137;
    localparam logic [LEVEL_W-1:0] RELEASE_RESET = 16'd9;

    // input modes
    localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;

    // controller to datapath
    typedef struct packed {
        logic latch;      // take the note, restart the voice counter
        logic on_step;    // note-on search over the current voice
        logic on_commit;  // claim the chosen voice, load the result
        logic off_step;   // release the current voice if it matches
        logic off_emit;   // load the note-off result
        logic tick_step;  // update the current voice, load its report
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic match;      // current voice is busy on the latched note
        logic last_idx;   // counter sits on the final voice
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

// ===== hw/rtl/pva_ctrl.sv =====
// Sequencer for the voice allocator: walks the voice table per event.
`timescale 1ns / 1ps

module pva_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [pva_pkg::MODE_W-1:0] i_mode,
    input  pva_pkg::t_sts             i_sts,
    output logic                      o_in_ready,
    output pva_pkg::t_cmd             o_cmd
);
    import pva_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_ON_SCAN   = 6'b000010,
        S_ON_COMMIT = 6'b000100,
        S_OFF_SCAN  = 6'b001000,
        S_OFF_DONE  = 6'b010000,
        S_TICK      = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_mode)
                        MODE_NOTE_ON:  n_state = S_ON_SCAN;
                        MODE_NOTE_OFF: n_state = S_OFF_SCAN;
                        MODE_TICK:     n_state = S_TICK;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_ON_SCAN: begin
                o_cmd.on_step = 1'b1;
                if (i_sts.match || i_sts.last_idx) begin
                    n_state = S_ON_COMMIT;
                end
            end
            S_ON_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.on_commit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_OFF_SCAN: begin
                o_cmd.off_step = 1'b1;
                if (i_sts.last_idx) begin
                    n_state = S_OFF_DONE;
                end
            end
            S_OFF_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.off_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TICK: begin
                if (i_sts.out_free) begin
                    o_cmd.tick_step = 1'b1;
                    if (i_sts.last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hw/rtl/pva_datapath.sv =====
// Voice table, envelope arithmetic, search registers and output register.
`timescale 1ns / 1ps

module pva_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pva_pkg::t_cmd                 i_cmd,
    output pva_pkg::t_sts                 o_sts,
    input  logic [pva_pkg::NOTE_W-1:0]    i_note,
    input  logic                          i_cfg_valid,
    input  logic [pva_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pva_pkg::LEVEL_W-1:0]   i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pva_pkg::KIND_W-1:0]    o_kind,
    output logic [pva_pkg::SLOT_W-1:0]    o_slot,
    output logic [pva_pkg::NOTE_W-1:0]    o_voice_note,
    output logic [pva_pkg::LEVEL_W-1:0]   o_level,
    output logic                          o_flag,
    output logic                          o_last
);
    import pva_pkg::*;

    // voice table
    logic                r_busy  [NUM_VOICES];
    logic [NOTE_W-1:0]   r_key   [NUM_VOICES];
    logic                r_held  [NUM_VOICES];
    logic [LEVEL_W-1:0]  r_lvl   [NUM_VOICES];

    logic [LEVEL_W-1:0]  r_attack;
    logic [LEVEL_W-1:0]  r_release;

    logic [NOTE_W-1:0]   r_note;
    logic [VOICE_W-1:0]  r_idx;

    // note-on search results
    logic                r_found;
    logic [VOICE_W-1:0]  r_found_idx;
    logic [LEVEL_W-1:0]  r_found_lvl;
    logic                r_free_vld;
    logic [VOICE_W-1:0]  r_free_idx;
    logic [VOICE_W-1:0]  r_quiet_idx;
    logic [LEVEL_W-1:0]  r_quiet_lvl;
    logic                r_any;

    // output register
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_kind;
    logic [SLOT_W-1:0]   r_slot;
    logic [NOTE_W-1:0]   r_vnote;
    logic [LEVEL_W-1:0]  r_level;
    logic                r_flag;
    logic                r_last;

    logic                cur_busy;
    logic [NOTE_W-1:0]   cur_key;
    logic                cur_held;
    logic [LEVEL_W-1:0]  cur_lvl;
    logic                cur_match;
    logic                last_idx;
    logic                out_free;
    logic [LEVEL_W:0]    att_sum;
    logic [LEVEL_W-1:0]  att_lvl;
    logic [LEVEL_W-1:0]  rel_lvl;
    logic                active;
    logic [LEVEL_W-1:0]  tick_lvl;
    logic                tick_free;
    logic [VOICE_W-1:0]  pick_idx;
    logic [LEVEL_W-1:0]  pick_lvl;
    logic                stolen;

    always_comb begin
        cur_busy  = r_busy[r_idx];
        cur_key   = r_key[r_idx];
        cur_held  = r_held[r_idx];
        cur_lvl   = r_lvl[r_idx];
        cur_match = cur_busy && (cur_key == r_note);
        last_idx  = (r_idx == VOICE_W'(NUM_VOICES - 1));
        out_free  = !r_out_valid || i_out_ready;

        // saturating envelope ramps
        att_sum   = {1'b0, cur_lvl} + {1'b0, r_attack};
        att_lvl   = (att_sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : att_sum[LEVEL_W-1:0];
        rel_lvl   = (cur_lvl > r_release) ? (cur_lvl - r_release) : '0;
        active    = cur_busy || (cur_lvl != '0);
        tick_lvl  = active ? (cur_held ? att_lvl : rel_lvl) : cur_lvl;
        tick_free = active && !cur_held && (tick_lvl == '0);

        // note-on choice: matching voice, else first free, else quietest
        stolen   = 1'b0;
        if (r_found) begin
            pick_idx = r_found_idx;
            pick_lvl = r_found_lvl;
        end else if (r_free_vld) begin
            pick_idx = r_free_idx;
            pick_lvl = '0;
        end else begin
            pick_idx = r_quiet_idx;
            pick_lvl = r_quiet_lvl;
            stolen   = 1'b1;
        end
    end

    assign o_sts = '{match: cur_match, last_idx: last_idx, out_free: out_free};

    // control registers and voice table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack    <= ATTACK_RESET;
            r_release   <= RELEASE_RESET;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_free_vld  <= 1'b0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_busy[i] <= 1'b0;
                r_key[i]  <= '0;
                r_held[i] <= 1'b0;
                r_lvl[i]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ATTACK:  r_attack  <= i_cfg_data;
                    CFG_RELEASE: r_release <= i_cfg_data;
                    default:     ;
                endcase
            end

            // load a new result, else drop the one just taken
            if (i_cmd.on_commit || i_cmd.off_emit || i_cmd.tick_step) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.latch) begin
                r_idx      <= '0;
                r_found    <= 1'b0;
                r_free_vld <= 1'b0;
                r_any      <= 1'b0;
            end

            if (i_cmd.on_step) begin
                r_idx <= r_idx + 1'b1;
                if (cur_match) begin
                    r_found <= 1'b1;
                end
                if (!cur_busy && (cur_lvl == '0) && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                end
            end

            if (i_cmd.on_commit) begin
                r_busy[pick_idx] <= 1'b1;
                r_key[pick_idx]  <= r_note;
                r_held[pick_idx] <= 1'b1;
            end

            if (i_cmd.off_step) begin
                r_idx <= r_idx + 1'b1;
                if (cur_match && cur_held) begin
                    r_held[r_idx] <= 1'b0;
                    r_any         <= 1'b1;
                end
            end

            if (i_cmd.tick_step) begin
                r_idx        <= r_idx + 1'b1;
                r_lvl[r_idx] <= tick_lvl;
                if (tick_free) begin
                    r_busy[r_idx] <= 1'b0;
                    r_key[r_idx]  <= '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_note <= i_note;
        end

        if (i_cmd.on_step) begin
            if (cur_match) begin
                r_found_idx <= r_idx;
                r_found_lvl <= cur_lvl;
            end
            if (!cur_busy && (cur_lvl == '0) && !r_free_vld) begin
                r_free_idx <= r_idx;
            end
            if ((r_idx == '0) || (cur_lvl < r_quiet_lvl)) begin
                r_quiet_idx <= r_idx;
                r_quiet_lvl <= cur_lvl;
            end
        end

        if (i_cmd.on_commit) begin
            r_kind  <= KIND_NOTE_ON;
            r_slot  <= SLOT_W'(pick_idx);
            r_vnote <= r_note;
            r_level <= pick_lvl;
            r_flag  <= stolen;
            r_last  <= 1'b1;
        end

        if (i_cmd.off_emit) begin
            r_kind  <= KIND_NOTE_OFF;
            r_slot  <= '0;
            r_vnote <= r_note;
            r_level <= '0;
            r_flag  <= r_any;
            r_last  <= 1'b1;
        end

        if (i_cmd.tick_step) begin
            r_kind  <= KIND_TICK;
            r_slot  <= SLOT_W'(r_idx);
            r_vnote <= (cur_busy && !tick_free) ? cur_key : '0;
            r_level <= tick_lvl;
            r_flag  <= cur_busy && !tick_free;
            r_last  <= last_idx;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_slot       = r_slot;
    assign o_voice_note = r_vnote;
    assign o_level      = r_level;
    assign o_flag       = r_flag;
    assign o_last       = r_last;

endmodule

// ===== hw/rtl/poly_voice_allocator_envelope.sv =====
// Top level of the polyphonic voice allocator with linear envelopes.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -----------------------------------
//  in        input      i_in_valid / o_in_ready    i_mode, i_note
//  out       output     o_out_valid / i_out_ready  o_kind, o_slot, o_voice_note,
//                                                  o_level, o_flag, o_last
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  Walk: after accepting an event the sequencer steps through the voice slots.
//  Note-on: searches up to NUM_VOICES slots (stops at a voice on the same
//  note), then commits. Note-off: walks all NUM_VOICES slots, then emits.
//  Tick: walks all NUM_VOICES slots, one report per slot, with the single
//  shared envelope adder/subtractor and the one-slot output register.
//  Reset: synchronous, clears the voice table and restores the step registers.
//  Stalls: a full output register holds the sequencer on emit steps only (all tick steps).
//
module poly_voice_allocator_envelope (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pva_pkg::MODE_W-1:0]    i_mode,
    input  logic [pva_pkg::NOTE_W-1:0]    i_note,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pva_pkg::KIND_W-1:0]    o_kind,
    output logic [pva_pkg::SLOT_W-1:0]    o_slot,
    output logic [pva_pkg::NOTE_W-1:0]    o_voice_note,
    output logic [pva_pkg::LEVEL_W-1:0]   o_level,
    output logic                          o_flag,
    output logic                          o_last,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pva_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pva_pkg::LEVEL_W-1:0]   i_cfg_data
);
    import pva_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // register writes land directly in the step registers, so the port never back-pressures
    assign o_cfg_ready = 1'b1;

    // sequencer: picks the walk for each transfer and paces it
    pva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // voice table, envelope math and the output register
    pva_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_note       (i_note),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_slot       (o_slot),
        .o_voice_note (o_voice_note),
        .o_level      (o_level),
        .o_flag       (o_flag),
        .o_last       (o_last)
    );

endmodule

// ===== test/poly_voice_allocator_envelope_test.sv =====
// Self-checking testbench for the polyphonic voice allocator with linear envelopes.
`timescale 1ns / 1ps

module poly_voice_allocator_envelope_test;
    import pva_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = NUM_VOICES + 4;  // one full voice walk plus margin
    localparam int QUIET_LIMIT    = 2000;            // cycles with no transfer on any channel
    localparam int ITEMS_PER_SET  = 46;              // counted events per register setting
    localparam int MAX_PRINTED    = 40;

    // codes outside the block's defined set
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [NOTE_W-1:0]  voice_note;
        logic [LEVEL_W-1:0] level;
        logic               flag;
        logic               last;
    } t_voice_report;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NOTE_W-1:0] note;
        logic              typed;   // want holds the one result, written out by hand
        t_voice_report     want;
    } t_score_row;

    typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_CLOGGED} t_sink_style;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [MODE_W-1:0]    i_mode      = '0;
    logic [NOTE_W-1:0]    i_note      = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LEVEL_W-1:0]   i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [KIND_W-1:0]    o_kind;
    logic [SLOT_W-1:0]    o_slot;
    logic [NOTE_W-1:0]    o_voice_note;
    logic [LEVEL_W-1:0]   o_level;
    logic                 o_flag;
    logic                 o_last;
    logic                 o_cfg_ready;

    poly_voice_allocator_envelope u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_note       (i_note),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_slot       (o_slot),
        .o_voice_note (o_voice_note),
        .o_level      (o_level),
        .o_flag       (o_flag),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Mirror of the voice table and the step registers
    // ------------------------------------------------------------------
    logic               tbl_busy  [NUM_VOICES];
    logic [NOTE_W-1:0]  tbl_key   [NUM_VOICES];
    logic               tbl_held  [NUM_VOICES];
    logic [LEVEL_W-1:0] tbl_level [NUM_VOICES];
    logic [LEVEL_W-1:0] attack_inc;
    logic [LEVEL_W-1:0] release_dec;

    t_voice_report voice_reports_due[$];   // results owed by the block, oldest first
    t_score_row    score_rows[$];

    int mismatches  = 0;
    int n_results   = 0;
    int n_note_on   = 0;
    int n_stolen    = 0;
    int n_note_off  = 0;
    int n_ticks     = 0;
    int n_ignored   = 0;
    int n_settings  = 1;
    int quiet_cycles = 0;
    int burst_left  = 0;
    int pool_base   = 0;

    // Append one owed result at the tail of the queue.
    task automatic owe_report(input t_voice_report r);
        voice_reports_due = {voice_reports_due, r};
    endtask

    task automatic clear_voice_table();
        for (int i = 0; i < NUM_VOICES; i++) begin
            tbl_busy[i]  = 1'b0;
            tbl_key[i]   = '0;
            tbl_held[i]  = 1'b0;
            tbl_level[i] = '0;
        end
        attack_inc  = ATTACK_RESET;
        release_dec = RELEASE_RESET;
    endtask

    // Apply one event to the mirror; queue the results it owes when keep is set.
    task automatic advance_voice_table(input logic [MODE_W-1:0] mode,
                                       input logic [NOTE_W-1:0] note, input bit keep);
        int            hit;
        int            free_idx;
        int            quiet;
        bit            any;
        logic [16:0]   sum;
        t_voice_report r;
        case (mode)
            MODE_NOTE_ON: begin
                hit = -1;
                free_idx = -1;
                quiet = 0;
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (tbl_busy[i] && tbl_key[i] == note) begin
                        hit = i;
                        break;
                    end
                    if (!tbl_busy[i] && tbl_level[i] == '0 && free_idx < 0) free_idx = i;
                    if (tbl_level[i] < tbl_level[quiet]) quiet = i;
                end
                r.flag = 1'b0;
                if (hit < 0) begin
                    if (free_idx >= 0) begin
                        hit = free_idx;
                    end else begin
                        // no voice free: steal the quietest, lowest slot on a tie
                        hit = quiet;
                        r.flag = 1'b1;
                        n_stolen++;
                    end
                end
                tbl_busy[hit] = 1'b1;
                tbl_key[hit]  = note;
                tbl_held[hit] = 1'b1;
                r.kind       = KIND_NOTE_ON;
                r.slot       = hit[SLOT_W-1:0];
                r.voice_note = note;
                r.level      = tbl_level[hit];
                r.last       = 1'b1;
                if (keep) owe_report(r);
            end
            MODE_NOTE_OFF: begin
                any = 1'b0;
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (tbl_busy[i] && tbl_key[i] == note && tbl_held[i]) begin
                        tbl_held[i] = 1'b0;
                        any = 1'b1;
                    end
                end
                r = '{KIND_NOTE_OFF, '0, note, '0, any, 1'b1};
                if (keep) owe_report(r);
            end
            MODE_TICK: begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    if (tbl_busy[i] || tbl_level[i] != '0) begin
                        if (tbl_held[i]) begin
                            sum = {1'b0, tbl_level[i]} + {1'b0, attack_inc};
                            tbl_level[i] = (sum > LEVEL_ONE) ? LEVEL_ONE : sum[LEVEL_W-1:0];
                        end else begin
                            tbl_level[i] = (tbl_level[i] > release_dec)
                                         ? tbl_level[i] - release_dec : '0;
                        end
                        // a released voice that hits silence goes back to the pool
                        if (!tbl_held[i] && tbl_level[i] == '0) begin
                            tbl_busy[i] = 1'b0;
                            tbl_key[i]  = '0;
                        end
                    end
                    r.kind       = KIND_TICK;
                    r.slot       = i[SLOT_W-1:0];
                    r.voice_note = tbl_busy[i] ? tbl_key[i] : '0;
                    r.level      = tbl_level[i];
                    r.flag       = tbl_busy[i];
                    r.last       = (i == NUM_VOICES - 1);
                    if (keep) owe_report(r);
                end
            end
            default: ;  // unused mode: no state change, no result
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_report(input t_voice_report got);
        t_voice_report want;
        n_results++;
        if (voice_reports_due.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none pending (kind %0d slot %0d)",
                                      n_results, got.kind, got.slot));
        end else begin
            want = voice_reports_due.pop_front();
            if (got.kind != want.kind)
                report_mismatch($sformatf("result %0d kind: want %0d got %0d",
                                          n_results, want.kind, got.kind));
            if (got.slot != want.slot)
                report_mismatch($sformatf("result %0d slot: want %0d got %0d",
                                          n_results, want.slot, got.slot));
            if (got.voice_note != want.voice_note)
                report_mismatch($sformatf("result %0d voice_note: want %0d got %0d",
                                          n_results, want.voice_note, got.voice_note));
            if (got.level != want.level)
                report_mismatch($sformatf("result %0d level: want %0d got %0d",
                                          n_results, want.level, got.level));
            if (got.flag != want.flag)
                report_mismatch($sformatf("result %0d flag: want %0d got %0d",
                                          n_results, want.flag, got.flag));
            if (got.last != want.last)
                report_mismatch($sformatf("result %0d last: want %0d got %0d",
                                          n_results, want.last, got.last));
        end
    endtask

    // Sample the result channel at the edge; every transfer is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_report({o_kind, o_slot, o_voice_note, o_level, o_flag, o_last});
    end

    // Result sink: switch between open, choppy and clogged stretches of random length.
    t_sink_style stall_style = SINK_OPEN;
    int          hold_left   = 0;
    always @(posedge i_clk) begin
        if (hold_left == 0) begin
            stall_style = t_sink_style'($urandom_range(0, 2));
            hold_left   = $urandom_range(4, 40);
        end else begin
            hold_left = hold_left - 1;
        end
        case (stall_style)
            SINK_OPEN:    i_out_ready <= 1'b1;
            SINK_CHOPPY:  i_out_ready <= ($urandom_range(0, 2) != 0);
            default:      i_out_ready <= (hold_left % 6 == 0);
        endcase
    end

    // Watchdog: count cycles in which no channel moves a transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no transfer for %0d cycles, %0d results still pending",
                 QUIET_LIMIT, voice_reports_due.size());
        $display("poly_voice_allocator_envelope verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Present one event and hold it until the transfer; the sender then
    // either keeps valid high for the next event or drops it for a gap.
    task automatic play_event(input logic [MODE_W-1:0] mode, input logic [NOTE_W-1:0] note,
                              input bit typed, input t_voice_report want);
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_note     <= note;
        do @(posedge i_clk); while (!o_in_ready);
        case (mode)
            MODE_NOTE_ON:  n_note_on++;
            MODE_NOTE_OFF: n_note_off++;
            MODE_TICK:     n_ticks++;
            default:       n_ignored++;
        endcase
        if (typed) owe_report(want);
        advance_voice_table(mode, note, !typed);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    // Wait for every owed result, then let the block finish any voice walk.
    task automatic drain_and_settle();
        while (voice_reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Back-to-back writes keep valid high; the caller lowers it after the batch.
    task automatic write_step_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [LEVEL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ATTACK:  attack_inc  = data;
            CFG_RELEASE: release_dec = data;
            default:     ;  // no register behind this index
        endcase
    endtask

    function automatic t_voice_report typed_report(input logic [KIND_W-1:0] kind,
            input int slot, input int note, input int level, input bit flag);
        return '{kind, slot[SLOT_W-1:0], note[NOTE_W-1:0], level[LEVEL_W-1:0], flag, 1'b1};
    endfunction

    task automatic add_row(input logic [MODE_W-1:0] mode, input int note,
                           input bit typed, input t_voice_report want);
        t_score_row row;
        row = '{mode, note[NOTE_W-1:0], typed, want};
        score_rows = {score_rows, row};
    endtask

    // Mostly a small pool of notes so that reuse, release and stealing happen;
    // the rest spread over the whole note range.
    task automatic play_random_set(input int count);
        int                counted;
        int                roll;
        logic [MODE_W-1:0] mode;
        logic [NOTE_W-1:0] note;
        counted = 0;
        pool_base = $urandom_range(0, 122);
        while (counted < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 38)      mode = MODE_NOTE_ON;
            else if (roll < 62) mode = MODE_NOTE_OFF;
            else if (roll < 95) mode = MODE_TICK;
            else                mode = MODE_UNUSED;
            if ($urandom_range(0, 3) == 0) note = NOTE_W'($urandom_range(0, 127));
            else                           note = NOTE_W'(pool_base + $urandom_range(0, 5));
            play_event(mode, note, 1'b0, '0);
            if (mode != MODE_UNUSED) counted++;
        end
    endtask

    // One register setting: write while idle, run random events, drain.
    task automatic run_setting(input logic [LEVEL_W-1:0] attack, input logic [LEVEL_W-1:0] rel,
                               input bit spare_writes);
        write_step_reg(CFG_ATTACK, attack);
        write_step_reg(CFG_RELEASE, rel);
        if (spare_writes) begin
            // writes past the register list must leave both steps alone
            write_step_reg(CFG_SPARE_2, 16'hFFFF);
            write_step_reg(CFG_SPARE_3, 16'h0000);
        end
        i_cfg_valid <= 1'b0;
        n_settings++;
        play_random_set(ITEMS_PER_SET);
        i_in_valid <= 1'b0;
        drain_and_settle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        clear_voice_table();
        burst_left = $urandom_range(1, 20);

        // Directed events at the reset steps (attack 137, release 9).
        // Hand-written rows: first voices after reset, a note-off with no match,
        // a release of a held voice and a repeated release of the same note.
        add_row(MODE_NOTE_ON,  0,   1, typed_report(KIND_NOTE_ON,  0, 0,   0, 1'b0));
        add_row(MODE_NOTE_ON,  127, 1, typed_report(KIND_NOTE_ON,  1, 127, 0, 1'b0));
        add_row(MODE_NOTE_OFF, 85,  1, typed_report(KIND_NOTE_OFF, 0, 85,  0, 1'b0));
        add_row(MODE_UNUSED,   42,  0, '0);   // ignored, no result
        add_row(MODE_TICK,     127, 0, '0);
        add_row(MODE_NOTE_ON,  0,   0, '0);   // reuse the voice already on this note
        add_row(MODE_NOTE_OFF, 0,   1, typed_report(KIND_NOTE_OFF, 0, 0,   0, 1'b1));
        add_row(MODE_NOTE_OFF, 0,   1, typed_report(KIND_NOTE_OFF, 0, 0,   0, 1'b0));
        for (int n = 10; n < 10 + NUM_VOICES - 2; n++) add_row(MODE_NOTE_ON, n, 0, '0);
        add_row(MODE_NOTE_ON,  20,  0, '0);   // table full: steal on a level tie
        add_row(MODE_TICK,     0,   0, '0);
        add_row(MODE_NOTE_ON,  33,  0, '0);   // steal the releasing, quietest voice
        add_row(MODE_NOTE_OFF, 127, 0, '0);
        add_row(MODE_TICK,     42,  0, '0);
        add_row(MODE_TICK,     85,  0, '0);
        add_row(MODE_NOTE_ON,  127, 0, '0);   // re-hold a releasing voice
        add_row(MODE_NOTE_OFF, 10,  0, '0);
        add_row(MODE_TICK,     0,   0, '0);
        foreach (score_rows[k])
            play_event(score_rows[k].mode, score_rows[k].note,
                       score_rows[k].typed, score_rows[k].want);
        i_in_valid <= 1'b0;
        drain_and_settle();

        // Register settings: top of range, minimum, zero, all ones, random, reset values.
        run_setting(16'd32768, 16'd32768, 1'b0);
        run_setting(16'd1,     16'd1,     1'b1);
        run_setting(16'd0,     16'd0,     1'b0);
        run_setting(16'hFFFF,  16'hFFFF,  1'b0);
        run_setting(LEVEL_W'($urandom_range(1, 32768)), LEVEL_W'($urandom_range(1, 32768)),
                    1'b1);
        run_setting(ATTACK_RESET, RELEASE_RESET, 1'b0);

        if (voice_reports_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", voice_reports_due.size()));

        $display("Covered %0d note-ons (%0d stolen), %0d note-offs, %0d ticks, %0d ignored",
                 n_note_on, n_stolen, n_note_off, n_ticks, n_ignored);
        $display("Checked %0d results over %0d step settings, %0d mismatches",
                 n_results, n_settings, mismatches);
        if (mismatches == 0)
            $display("poly_voice_allocator_envelope verification clean");
        else
            $display("poly_voice_allocator_envelope verification failed");
        $finish;
    end

endmodule

// ===== poly_voice_allocator_envelope.f =====
hw/rtl/pva_pkg.sv
hw/rtl/pva_ctrl.sv
hw/rtl/pva_datapath.sv
hw/rtl/poly_voice_allocator_envelope.sv
test/poly_voice_allocator_envelope_test.sv
